// ===== rtl/pmdf_pkg.sv =====
// Shared types and constants of the peer message duplicate filter.
package pmdf_pkg;

  localparam int ADDR_W = 48;
  localparam int KIND_W = 2;
  localparam int SEQ_W  = 32;

  typedef enum logic {
    ACT_ADD   = 1'b0,
    ACT_ERASE = 1'b1
  } pmdf_act_e;

  typedef struct packed {
    logic active;
    logic hit;
    logic acc;
    logic free_seen;
  } pmdf_tok_t;

  typedef struct packed {
    pmdf_act_e           action;
    logic [ADDR_W-1:0]   addr;
    logic [KIND_W-1:0]   kind;
    logic                claim;
  } pmdf_cmd_t;

endpackage

// ===== rtl/pmdf_in_if.sv =====
// Input channel of the duplicate filter: one beat per message record or erase.
interface pmdf_in_if;
  import pmdf_pkg::*;

  logic              valid;
  logic              ready;
  logic              action;
  logic [ADDR_W-1:0] sender_addr;
  logic [KIND_W-1:0] kind;
  logic [SEQ_W-1:0]  seq_id;

  modport source (output valid, action, sender_addr, kind, seq_id, input ready);
  modport sink   (input valid, action, sender_addr, kind, seq_id, output ready);
endinterface

// ===== rtl/pmdf_out_if.sv =====
// Result channel of the duplicate filter: one beat per accepted input beat.
interface pmdf_out_if;
  logic valid;
  logic ready;
  logic accepted;
  logic table_full;

  modport source (output valid, accepted, table_full, input ready);
  modport sink   (input valid, accepted, table_full, output ready);
endinterface

// ===== rtl/pmdf_cell.sv =====
// One table entry of the duplicate filter, visited by the search token in turn.
module pmdf_cell #(
  parameter int KINDS   = 4,
  parameter int ID_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pmdf_pkg::pmdf_cmd_t cmd_i,
  input  logic [ID_BITS-1:0] id_i,
  input  pmdf_pkg::pmdf_tok_t tok_i,
  output pmdf_pkg::pmdf_tok_t tok_o
);
  import pmdf_pkg::*;

  localparam int KIDX_W = (KINDS > 1) ? $clog2(KINDS) : 1;

  logic               used_q, used_d;
  logic               cand_q, cand_d;
  logic [KINDS-1:0]   seen_q, seen_d;
  logic [ADDR_W-1:0]  addr_q;
  logic [ID_BITS-1:0] top_q [KINDS];
  pmdf_tok_t          tok_q, tok_d;

  logic [KIDX_W-1:0]  kidx;
  logic               here, match, seen_bit, newer, upd, take, wr_id;

  always_comb begin
    kidx     = KIDX_W'(cmd_i.kind);
    here     = tok_i.active;
    match    = used_q && (addr_q == cmd_i.addr);
    seen_bit = seen_q[kidx];
    newer    = !seen_bit || (top_q[kidx] < id_i);
    upd      = here && match && (cmd_i.action == ACT_ADD) && newer;
    take     = cmd_i.claim && cand_q;
    wr_id    = upd || take;

    tok_d.active    = here;
    tok_d.hit       = tok_i.hit | (here && match);
    tok_d.acc       = tok_i.acc | upd;
    tok_d.free_seen = tok_i.free_seen | (here && !used_q);

    used_d = used_q;
    seen_d = seen_q;
    cand_d = cand_q;
    if (here) begin
      cand_d = !used_q && !tok_i.free_seen;
    end
    if (here && match && (cmd_i.action == ACT_ERASE)) begin
      used_d = 1'b0;
      seen_d = '0;
    end
    if (upd) begin
      seen_d[kidx] = 1'b1;
    end
    if (take) begin
      used_d       = 1'b1;
      seen_d       = '0;
      seen_d[kidx] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
      cand_q <= 1'b0;
      seen_q <= '0;
      tok_q  <= '0;
    end else begin
      used_q <= used_d;
      cand_q <= cand_d;
      seen_q <= seen_d;
      tok_q  <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      addr_q <= cmd_i.addr;
    end
    if (wr_id) begin
      top_q[kidx] <= id_i;
    end
  end

  assign tok_o = tok_q;

endmodule

// ===== rtl/peer_message_duplicate_filter.sv =====
// Top level of the peer message duplicate filter: control, query register, row of entries.
// Each table entry is one cell in a row; an item's search token walks the row one cell per
// cycle. A new input beat is taken only once that walk is over and the result moves to the
// output register (an add with address zero or a kind of KINDS or more skips it). A cell
// that matches the sender address updates itself as the token passes; a new address is
// written into the lowest free cell in the cycle the token leaves the row. The result sits
// in an output register, so a new input beat is taken while the previous result waits.
// After reset every entry is free at once.
module peer_message_duplicate_filter #(
  parameter int SLOTS   = 16,
  parameter int KINDS   = 4,
  parameter int ID_BITS = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  pmdf_in_if.sink       in_i,
  pmdf_out_if.source    out_o
);
  import pmdf_pkg::*;

  localparam logic [4:0] KINDS_L = 5'(KINDS);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WALK = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  state_e              state_q, state_d;
  logic                start_q, start_d;
  pmdf_act_e           act_q;
  logic [ADDR_W-1:0]   addr_q;
  logic [KIND_W-1:0]   kind_q;
  logic [ID_BITS-1:0]  id_q;
  logic                res_acc_q, res_acc_d;
  logic                res_full_q, res_full_d;
  logic                out_valid_q, out_valid_d;
  logic                out_acc_q, out_full_q;

  logic                in_fire, bad_add, claim, out_load;
  pmdf_cmd_t           cmd;
  pmdf_tok_t           tok_w [SLOTS+1];
  pmdf_tok_t           tail;
  logic [SLOTS-1:0]    tok_act;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign bad_add    = (in_i.action == ACT_ADD) &&
                      ((in_i.sender_addr == '0) || (5'(in_i.kind) >= KINDS_L));
  assign tail       = tok_w[SLOTS];
  assign claim      = (state_q == ST_WALK) && tail.active && (act_q == ACT_ADD) &&
                      !tail.hit && tail.free_seen;

  assign cmd.action = act_q;
  assign cmd.addr   = addr_q;
  assign cmd.kind   = kind_q;
  assign cmd.claim  = claim;

  assign tok_w[0] = '{active: start_q, hit: 1'b0, acc: 1'b0, free_seen: 1'b0};

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    pmdf_cell #(
      .KINDS   (KINDS),
      .ID_BITS (ID_BITS)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cmd_i  (cmd),
      .id_i   (id_q),
      .tok_i  (tok_w[g]),
      .tok_o  (tok_w[g+1])
    );
    assign tok_act[g] = tok_w[g+1].active;
  end

  always_comb begin
    state_d    = state_q;
    start_d    = 1'b0;
    res_acc_d  = res_acc_q;
    res_full_d = res_full_q;
    out_load   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (bad_add) begin
            res_acc_d  = 1'b0;
            res_full_d = 1'b0;
            state_d    = ST_DONE;
          end else begin
            start_d = 1'b1;
            state_d = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        if (tail.active) begin
          state_d = ST_DONE;
          if (act_q == ACT_ERASE) begin
            res_acc_d  = tail.hit;
            res_full_d = 1'b0;
          end else begin
            res_acc_d  = tail.hit ? tail.acc : tail.free_seen;
            res_full_d = !tail.hit && !tail.free_seen;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      start_q     <= start_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      act_q  <= pmdf_act_e'(in_i.action);
      addr_q <= in_i.sender_addr;
      kind_q <= in_i.kind;
      id_q   <= ID_BITS'(in_i.seq_id);
    end
    res_acc_q  <= res_acc_d;
    res_full_q <= res_full_d;
    if (out_load) begin
      out_acc_q  <= res_acc_q;
      out_full_q <= res_full_q;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.accepted   = out_acc_q;
  assign out_o.table_full = out_full_q;

  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok_act))
    else $error("more than one search token in the row");

  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (tok_act == '0) && !start_q)
    else $error("search token alive while idle");

  a_tail_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail.active |-> (state_q == ST_WALK))
    else $error("token left the row outside a walk");

  a_res_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_acc_q && out_full_q))
    else $error("result both accepted and table full");

  a_claim_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    claim |=> (state_q == ST_DONE) && res_acc_q && !res_full_q)
    else $error("new entry claimed without an accepted result");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of the peer message duplicate filter with a table predictor.
module tb;
  import pmdf_pkg::*;

  localparam int SLOTS       = 16;
  localparam int KINDS       = 4;
  localparam int POOL_N      = 24;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 210;
  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 3000;

  typedef struct {
    logic accepted;
    logic table_full;
  } verdict_t;

  class dup_filter_model;
    bit                used[SLOTS];
    logic [ADDR_W-1:0] owner[SLOTS];
    bit   [KINDS-1:0]  seen[SLOTS];
    logic [SEQ_W-1:0]  top_id[SLOTS][KINDS];
    verdict_t          verdicts[$];
    int                errors;

    function new();
      errors = 0;
      foreach (used[i]) begin
        used[i] = 1'b0;
        seen[i] = '0;
      end
    endfunction

    function int slot_of(logic [ADDR_W-1:0] a);
      for (int i = 0; i < SLOTS; i++) begin
        if (used[i] && owner[i] == a) return i;
      end
      return -1;
    endfunction

    function int free_slot();
      for (int i = 0; i < SLOTS; i++) begin
        if (!used[i]) return i;
      end
      return -1;
    endfunction

    function void log_message(pmdf_act_e act, logic [ADDR_W-1:0] a,
                              logic [KIND_W-1:0] k, logic [SEQ_W-1:0] id);
      verdict_t v;
      int       s;
      v.accepted   = 1'b0;
      v.table_full = 1'b0;
      s = slot_of(a);
      if (act == ACT_ERASE) begin
        if (s >= 0) begin
          used[s]    = 1'b0;
          seen[s]    = '0;
          v.accepted = 1'b1;
        end
      end else if (a != '0 && int'(k) < KINDS) begin
        if (s < 0) begin
          s = free_slot();
          if (s < 0) begin
            v.table_full = 1'b1;
          end else begin
            used[s]      = 1'b1;
            owner[s]     = a;
            seen[s]      = '0;
            seen[s][k]   = 1'b1;
            top_id[s][k] = id;
            v.accepted   = 1'b1;
          end
        end else if (!seen[s][k] || top_id[s][k] < id) begin
          seen[s][k]   = 1'b1;
          top_id[s][k] = id;
          v.accepted   = 1'b1;
        end
      end
      verdicts.push_back(v);
    endfunction

    function void match_verdict(logic acc, logic full);
      verdict_t v;
      if (verdicts.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, accepted %b table_full %b", $time, acc, full);
        return;
      end
      v = verdicts.pop_front();
      if (acc !== v.accepted) begin
        errors++;
        $display("%0t: accepted mismatch, expected %b actual %b", $time, v.accepted, acc);
      end
      if (full !== v.table_full) begin
        errors++;
        $display("%0t: table_full mismatch, expected %b actual %b",
                 $time, v.table_full, full);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  pmdf_in_if  in_ch();
  pmdf_out_if out_ch();

  peer_message_duplicate_filter #(
    .SLOTS  (SLOTS),
    .KINDS  (KINDS),
    .ID_BITS(SEQ_W)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  dup_filter_model   filter = new();
  logic [ADDR_W-1:0] pool[POOL_N];
  int                src_idle_pct = 0;
  int                snk_idle_pct = 0;
  bit                hold_req = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Receiver: random stalls, or a long hold-off on request.
  initial begin
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end
      out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
      @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      filter.match_verdict(out_ch.accepted, out_ch.table_full);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= QUIET_LIMIT) begin
        $display("FAIL peer_message_duplicate_filter");
        $finish;
      end
    end
  end

  task automatic offer_beat(pmdf_act_e act, logic [ADDR_W-1:0] a,
                            logic [KIND_W-1:0] k, logic [SEQ_W-1:0] id);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid       <= 1'b1;
    in_ch.action      <= act;
    in_ch.sender_addr <= a;
    in_ch.kind        <= k;
    in_ch.seq_id      <= id;
    do begin
      @(posedge clk_i);
    end while (!in_ch.ready);
    filter.log_message(act, a, k, id);
  endtask

  task automatic wait_results();
    in_ch.valid <= 1'b0;
    while (filter.verdicts.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [SEQ_W-1:0] pick_id();
    int r;
    r = $urandom_range(99);
    if (r < 50) return SEQ_W'($urandom_range(40));
    if (r < 60) return '1 - SEQ_W'($urandom_range(20));
    if (r < 70) return ($urandom_range(1) != 0) ? '1 : '0;
    return $urandom;
  endfunction

  task automatic random_item();
    logic [ADDR_W-1:0] a;
    int                r;
    r = $urandom_range(99);
    a = ADDR_W'({$urandom, $urandom});
    if (r < 15) begin
      offer_beat(ACT_ERASE, pool[$urandom_range(POOL_N - 1)], 2'($urandom), pick_id());
    end else if (r < 18) begin
      offer_beat(ACT_ERASE, a, 2'($urandom), pick_id());
    end else if (r < 20) begin
      offer_beat(ACT_ADD, '0, 2'($urandom), pick_id());
    end else if (r < 23) begin
      offer_beat(ACT_ADD, a, 2'($urandom), pick_id());
    end else begin
      offer_beat(ACT_ADD, pool[$urandom_range(POOL_N - 1)], 2'($urandom), pick_id());
    end
  endtask

  initial begin
    rst_ni            <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.action      <= ACT_ADD;
    in_ch.sender_addr <= '0;
    in_ch.kind        <= '0;
    in_ch.seq_id      <= '0;
    foreach (pool[i]) begin
      pool[i] = ADDR_W'({$urandom, $urandom});
      if (pool[i] == '0) pool[i] = 1;
    end
    pool[POOL_N-1] = '1;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    offer_beat(ACT_ADD, '0, 2'd0, 32'd7);
    offer_beat(ACT_ERASE, '0, 2'd0, 32'd0);
    offer_beat(ACT_ERASE, pool[5], 2'd1, 32'd0);
    offer_beat(ACT_ADD, pool[0], 2'd0, 32'd5);
    offer_beat(ACT_ADD, pool[0], 2'd0, 32'd5);
    offer_beat(ACT_ADD, pool[0], 2'd0, 32'd4);
    offer_beat(ACT_ADD, pool[0], 2'd0, 32'd6);
    offer_beat(ACT_ADD, pool[0], 2'd3, '1);
    offer_beat(ACT_ADD, pool[0], 2'd3, '1);
    offer_beat(ACT_ADD, pool[POOL_N-1], 2'd1, '0);
    for (int i = 1; i <= SLOTS - 2; i++) begin
      offer_beat(ACT_ADD, pool[i], 2'(i), $urandom);
    end
    offer_beat(ACT_ADD, pool[SLOTS-1], 2'd2, 32'd1);
    offer_beat(ACT_ERASE, pool[0], 2'd0, 32'd0);
    offer_beat(ACT_ADD, pool[SLOTS-1], 2'd2, 32'd0);
    offer_beat(ACT_ERASE, pool[0], 2'd0, 32'd0);
    wait_results();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph % 4)
        0: begin
          src_idle_pct = 0;
          snk_idle_pct = 0;
        end
        1: begin
          src_idle_pct = 61;
          snk_idle_pct = 0;
        end
        2: begin
          src_idle_pct = 0;
          snk_idle_pct = 61;
        end
        default: begin
          src_idle_pct = 6;
          snk_idle_pct = 6;
        end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 0 && n == PHASE_ITEMS / 2) hold_req = 1'b1;
        random_item();
      end
      wait_results();
    end

    repeat (2 * (SLOTS + 3)) @(posedge clk_i);
    if (filter.errors == 0 && filter.verdicts.size() == 0) begin
      $display("PASS peer_message_duplicate_filter");
    end else begin
      $display("%0t: %0d results still expected", $time, filter.verdicts.size());
      $display("FAIL peer_message_duplicate_filter");
    end
    $finish;
  end

endmodule
